>>> design/ggpc_pkg.sv
`timescale 1ns / 1ps
package ggpc_pkg;

  localparam int unsigned CNT_W  = 6;
  localparam int unsigned ITER_W = 5;
  localparam int unsigned CX_W   = 60;
  localparam int unsigned NUM_REGS = 7;

  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd31;

  localparam logic signed [33:0]     PI_Q29          = 34'sd1686629713;
  localparam logic signed [33:0]     RPM_SCALE_Q32   = 34'sd4101392;
  localparam logic signed [33:0]     DT_Q32          = 34'sd42949673;
  localparam logic signed [33:0]     DT_BANG_Q16     = 34'sd6835653;
  localparam logic signed [CX_W-1:0] CORDIC_INV_GAIN = 60'sd652032874;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_CHK, ST_VEC, ST_ERR, ST_ROT1, ST_TRIG1,
    ST_PROJ, ST_ERRRAD, ST_LIN, ST_ANG, ST_WL1, ST_WL2, ST_WSUM, ST_LEFT, ST_RIGHT,
    ST_HEAD, ST_ROT2, ST_TRIG2, ST_CX, ST_SX, ST_DX, ST_DY, ST_DH, ST_UPDH, ST_DONE
  } ggpc_state_e;

  typedef struct packed {
    ggpc_state_e       op;
    logic [ITER_W-1:0] iter;
    logic              take_in;
    logic              load_out;
  } ggpc_cmd_t;

  typedef struct packed {
    logic arrive;
  } ggpc_stat_t;

  function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> design/ggpc_cordic.sv
`timescale 1ns / 1ps
module ggpc_cordic import ggpc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  logic                   run_i,
  input  logic                   vec_i,
  input  logic signed [CX_W-1:0] x_i,
  input  logic signed [CX_W-1:0] y_i,
  input  logic [31:0]            z_i,
  input  logic [ITER_W-1:0]      iter_i,
  output logic signed [CX_W-1:0] x_o,
  output logic signed [CX_W-1:0] y_o,
  output logic [31:0]            z_o
);

  logic signed [CX_W-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic [31:0] z_q, z_d, at;
  logic dir;

  always_comb begin
    xs  = y_q >>> iter_i;
    ys  = x_q >>> iter_i;
    at  = atan_lut(iter_i);
    dir = vec_i ? (y_q[CX_W-1] || (y_q == '0)) : !z_q[31];
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (load_i) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (run_i) begin
      if (dir) begin
        x_d = x_q - xs;
        y_d = y_q + ys;
        z_d = z_q - at;
      end else begin
        x_d = x_q + xs;
        y_d = y_q - ys;
        z_d = z_q + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> design/ggpc_dp.sv
`timescale 1ns / 1ps
module ggpc_dp import ggpc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ggpc_cmd_t          cmd_i,
  output ggpc_stat_t         stat_o,
  input  logic signed [31:0] goal_x_i,
  input  logic signed [31:0] goal_y_i,
  input  logic [23:0]        lin_gain_i,
  input  logic [23:0]        ang_gain_i,
  input  logic [23:0]        lin_lim_i,
  input  logic [23:0]        ang_lim_i,
  input  logic [23:0]        tol_i,
  input  logic [23:0]        inv_rad_i,
  input  logic [23:0]        half_trk_i,
  output logic [31:0]        left_setpoint_o,
  output logic [31:0]        right_setpoint_o,
  output logic [31:0]        lin_cmd_o,
  output logic [31:0]        ang_cmd_o,
  output logic [31:0]        pose_x_o,
  output logic [31:0]        pose_y_o,
  output logic [15:0]        pose_heading_o,
  output logic               arrived_o
);

  localparam int unsigned OPA_W  = (51 - FRAC_BITS > 34) ? 51 - FRAC_BITS : 34;
  localparam int unsigned OPB_W  = 34;
  localparam int unsigned PW     = OPA_W + OPB_W;
  localparam int unsigned SH_ERR = 44 - FRAC_BITS;
  localparam int unsigned SH_HD  = FRAC_BITS + 16;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                               input int unsigned s);
    logic signed [PW-1:0] half;
    logic signed [PW-1:0] sum;
    half = $signed(PW'(1) << (s - 1));
    sum  = v + half;
    return sum >>> s;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
    logic [31:0] r;
    if ((&v[PW-1:31]) || !(|v[PW-1:31])) r = v[31:0];
    else if (v[PW-1]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

  function automatic logic signed [24:0] clampmag(input logic signed [PW-1:0] v,
                                                  input logic [23:0] lim);
    logic signed [PW-1:0] l;
    logic signed [PW-1:0] nl;
    logic signed [PW-1:0] r;
    l  = $signed(PW'(lim));
    nl = -l;
    if (v > l) r = l;
    else if (v < nl) r = nl;
    else r = v;
    return r[24:0];
  endfunction

  function automatic logic [32:0] fold(input logic signed [15:0] a);
    logic signed [16:0] t;
    logic neg;
    t   = 17'(a);
    neg = 1'b0;
    if (t > 17'sd16384) begin
      t   = t - 17'sd32768;
      neg = 1'b1;
    end else if (t < -17'sd16384) begin
      t   = t + 17'sd32768;
      neg = 1'b1;
    end
    return {neg, t[15:0], 16'h0000};
  endfunction

  logic signed [31:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [32:0] dfx, dfy;
  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [PW-1:0] r30, rerr, rf, r32, rhd, wsum, wdif, nx, ny;
  logic [63:0] acc_q, rem_q, root_q, bit_q, trial;
  logic zero_q, arrived_q, neg_q;
  logic signed [15:0] err_q, err_d, fold_in;
  logic [15:0] bear;
  logic [32:0] fold_out;
  logic signed [33:0] c_q, s_q, proj_q, errrad_q, tx_q, ty_q, cneg, sneg;
  logic signed [24:0] lin_q, ang_q;
  logic signed [49:0] t1_q;
  logic signed [OPA_W-1:0] wl_q, wr_q;
  logic [31:0] left_q, right_q;
  logic signed [31:0] est_x_q, est_y_q;
  logic signed [15:0] est_hd_q;
  logic [31:0] rpm_left, rpm_right;

  logic                   cl_load, cl_run, cl_vec;
  logic signed [CX_W-1:0] cl_x, cl_y, cx, cy, xv, yv;
  logic [31:0]            cl_z, cz, bsum;

  always_comb begin
    dfx  = 33'(goal_x_i) - 33'(est_x_q);
    dfy  = 33'(goal_y_i) - 33'(est_y_q);
    dx_d = (dfx[32] != dfx[31]) ? (dfx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dfx[31:0];
    dy_d = (dfy[32] != dfy[31]) ? (dfy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dfy[31:0];
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.op)
      ST_SQX:    begin opa = OPA_W'(dx_q);           opb = OPB_W'(dx_q);     end
      ST_SQY:    begin opa = OPA_W'(dy_q);           opb = OPB_W'(dy_q);     end
      ST_PROJ:   begin opa = OPA_W'(root_q[31:0]);   opb = c_q;              end
      ST_ERRRAD: begin opa = OPA_W'(err_q);          opb = PI_Q29;           end
      ST_LIN:    begin opa = OPA_W'(lin_gain_i);     opb = proj_q;           end
      ST_ANG:    begin opa = OPA_W'(ang_gain_i);     opb = errrad_q;         end
      ST_WL1:    begin opa = OPA_W'(inv_rad_i);      opb = OPB_W'(lin_q);    end
      ST_WL2:    begin opa = OPA_W'(half_trk_i);     opb = OPB_W'(ang_q);    end
      ST_LEFT:   begin opa = wl_q;                   opb = RPM_SCALE_Q32;    end
      ST_RIGHT:  begin opa = wr_q;                   opb = RPM_SCALE_Q32;    end
      ST_CX:     begin opa = OPA_W'(lin_q);          opb = c_q;              end
      ST_SX:     begin opa = OPA_W'(lin_q);          opb = s_q;              end
      ST_DX:     begin opa = OPA_W'(tx_q);           opb = DT_Q32;           end
      ST_DY:     begin opa = OPA_W'(ty_q);           opb = DT_Q32;           end
      ST_DH:     begin opa = OPA_W'(ang_q);          opb = DT_BANG_Q16;      end
      default:   begin opa = '0;                     opb = '0;               end
    endcase
    prod_d = opa * opb;
  end

  always_comb begin
    r30  = rnd(prod_q, 30);
    rerr = rnd(prod_q, SH_ERR);
    rf   = rnd(prod_q, FRAC_BITS);
    r32  = rnd(prod_q, 32);
    rhd  = rnd(prod_q, SH_HD);
    wsum = rnd(PW'(t1_q) + prod_q, FRAC_BITS);
    wdif = rnd(PW'(t1_q) - prod_q, FRAC_BITS);
    nx   = PW'(est_x_q) + r32;
    ny   = PW'(est_y_q) + r32;
    rpm_left  = sat32(r32);
    rpm_right = sat32(r32);
    trial = root_q + bit_q;
  end

  always_comb begin
    bsum     = cz + 32'h0000_8000;
    bear     = zero_q ? 16'h0000 : bsum[31:16];
    err_d    = $signed(bear - est_hd_q);
    fold_in  = (cmd_i.op == ST_HEAD) ? est_hd_q : err_d;
    fold_out = fold(fold_in);
    xv       = CX_W'(dx_q) <<< 24;
    yv       = CX_W'(dy_q) <<< 24;
    cl_load  = 1'b0;
    cl_x     = CORDIC_INV_GAIN;
    cl_y     = '0;
    cl_z     = fold_out[31:0];
    case (cmd_i.op)
      ST_CHK: begin
        cl_load = 1'b1;
        cl_x    = dx_q[31] ? -xv : xv;
        cl_y    = dx_q[31] ? -yv : yv;
        cl_z    = dx_q[31] ? 32'h8000_0000 : 32'h0000_0000;
      end
      ST_ERR, ST_HEAD: cl_load = 1'b1;
      default: cl_load = 1'b0;
    endcase
    cl_run = cmd_i.op inside {ST_VEC, ST_ROT1, ST_ROT2};
    cl_vec = cmd_i.op == ST_VEC;
    cneg   = -cx[33:0];
    sneg   = -cy[33:0];
  end

  ggpc_cordic u_cordic (
    .clk_i  (clk_i),
    .load_i (cl_load),
    .run_i  (cl_run),
    .vec_i  (cl_vec),
    .x_i    (cl_x),
    .y_i    (cl_y),
    .z_i    (cl_z),
    .iter_i (cmd_i.iter),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz)
  );

  assign stat_o.arrive = root_q < 64'(tol_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      ST_IDLE: begin
        if (cmd_i.take_in) begin
          dx_q <= dx_d;
          dy_q <= dy_d;
        end
      end
      ST_SQY: acc_q <= prod_q[63:0];
      ST_SUM: begin
        rem_q  <= acc_q + prod_q[63:0];
        root_q <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_CHK: begin
        arrived_q <= stat_o.arrive;
        zero_q    <= (dx_q == '0) && (dy_q == '0);
      end
      ST_ERR: begin
        err_q <= err_d;
        neg_q <= fold_out[32];
      end
      ST_HEAD: begin
        right_q <= rpm_right;
        neg_q   <= fold_out[32];
      end
      ST_TRIG1, ST_TRIG2: begin
        c_q <= neg_q ? cneg : cx[33:0];
        s_q <= neg_q ? sneg : cy[33:0];
      end
      ST_ERRRAD: proj_q   <= r30[33:0];
      ST_LIN:    errrad_q <= rerr[33:0];
      ST_ANG:    lin_q    <= clampmag(rf, lin_lim_i);
      ST_WL1:    ang_q    <= clampmag(rf, ang_lim_i);
      ST_WL2:    t1_q     <= prod_q[49:0];
      ST_WSUM: begin
        wl_q <= wdif[OPA_W-1:0];
        wr_q <= wsum[OPA_W-1:0];
      end
      ST_RIGHT: left_q <= rpm_left;
      ST_SX:    tx_q   <= r30[33:0];
      ST_DX:    ty_q   <= r30[33:0];
      ST_DONE: begin
        if (cmd_i.load_out) begin
          left_setpoint_o  <= arrived_q ? 32'h0 : left_q;
          right_setpoint_o <= arrived_q ? 32'h0 : right_q;
          lin_cmd_o        <= arrived_q ? 32'h0 : 32'(lin_q);
          ang_cmd_o        <= arrived_q ? 32'h0 : 32'(ang_q);
          pose_x_o         <= est_x_q;
          pose_y_o         <= est_y_q;
          pose_heading_o   <= est_hd_q;
          arrived_o        <= arrived_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_x_q  <= '0;
      est_y_q  <= '0;
      est_hd_q <= '0;
    end else begin
      case (cmd_i.op)
        ST_DY:   est_x_q  <= sat32(nx);
        ST_DH:   est_y_q  <= sat32(ny);
        ST_UPDH: est_hd_q <= est_hd_q + rhd[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/ggpc_ctrl.sv
`timescale 1ns / 1ps
module ggpc_ctrl import ggpc_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ggpc_stat_t stat_i,
  output ggpc_cmd_t  cmd_o
);

  localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);

  ggpc_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic load;

  assign load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQX;
      ST_SQX:    state_d = ST_SQY;
      ST_SQY:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_SQRT;
      ST_SQRT: begin
        if (cnt_q == SQRT_LAST) state_d = ST_CHK;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_CHK:    state_d = stat_i.arrive ? ST_DONE : ST_VEC;
      ST_VEC: begin
        if (cnt_q == ROT_LAST) state_d = ST_ERR;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_ERR:    state_d = ST_ROT1;
      ST_ROT1: begin
        if (cnt_q == ROT_LAST) state_d = ST_TRIG1;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_TRIG1:  state_d = ST_PROJ;
      ST_PROJ:   state_d = ST_ERRRAD;
      ST_ERRRAD: state_d = ST_LIN;
      ST_LIN:    state_d = ST_ANG;
      ST_ANG:    state_d = ST_WL1;
      ST_WL1:    state_d = ST_WL2;
      ST_WL2:    state_d = ST_WSUM;
      ST_WSUM:   state_d = ST_LEFT;
      ST_LEFT:   state_d = ST_RIGHT;
      ST_RIGHT:  state_d = ST_HEAD;
      ST_HEAD:   state_d = ST_ROT2;
      ST_ROT2: begin
        if (cnt_q == ROT_LAST) state_d = ST_TRIG2;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_TRIG2:  state_d = ST_CX;
      ST_CX:     state_d = ST_SX;
      ST_SX:     state_d = ST_DX;
      ST_DX:     state_d = ST_DY;
      ST_DY:     state_d = ST_DH;
      ST_DH:     state_d = ST_UPDH;
      ST_UPDH:   state_d = ST_DONE;
      ST_DONE: begin
        if (load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = state_q;
    cmd_o.iter     = cnt_q[ITER_W-1:0];
    cmd_o.take_in  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load_out = load;
    in_ready_o     = state_q == ST_IDLE;
    out_valid_o    = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SQX))
    else $error("accepted item did not start");

  a_cordic_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VEC || state_q == ST_ROT1 || state_q == ST_ROT2) |-> (cnt_q <= ROT_LAST))
    else $error("rotation counter overrun");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");
`endif

endmodule

>>> design/go_to_goal_pose_controller_top.sv
// Each goal runs through the state sequence from input accept to m_axis_tvalid; the bearing,
// CORDIC and command states are skipped when the goal is within the arrival tolerance.
// Goals do not overlap; a new goal is accepted only in idle. Time per goal is set by the
// 32-step square root, three passes of the single shared CORDIC and the shared multiplier.
// Reset: asynchronous, active low; clears pose to zero and loads register defaults.
`timescale 1ns / 1ps
module go_to_goal_pose_controller_top import ggpc_pkg::*; #(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,   // goal_x, goal_y
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // left_setpoint, right_setpoint, lin_cmd, ang_cmd, pose_x, pose_y, pose_heading
  output logic [207:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o,   // arrived
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] REG_LIN_GAIN = 3'd0;
  localparam logic [2:0] REG_ANG_GAIN = 3'd1;
  localparam logic [2:0] REG_LIN_LIM  = 3'd2;
  localparam logic [2:0] REG_ANG_LIM  = 3'd3;
  localparam logic [2:0] REG_TOL      = 3'd4;
  localparam logic [2:0] REG_INV_RAD  = 3'd5;
  localparam logic [2:0] REG_HALF_TRK = 3'd6;

  logic [23:0] lin_gain_q, ang_gain_q, lin_lim_q, ang_lim_q, tol_q, inv_rad_q, half_trk_q;
  logic [2:0]  idx;
  logic        wr_en;
  ggpc_cmd_t   cmd;
  ggpc_stat_t  stat;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (idx)
      REG_LIN_GAIN: prdata = {8'h00, lin_gain_q};
      REG_ANG_GAIN: prdata = {8'h00, ang_gain_q};
      REG_LIN_LIM:  prdata = {8'h00, lin_lim_q};
      REG_ANG_LIM:  prdata = {8'h00, ang_lim_q};
      REG_TOL:      prdata = {8'h00, tol_q};
      REG_INV_RAD:  prdata = {8'h00, inv_rad_q};
      REG_HALF_TRK: prdata = {8'h00, half_trk_q};
      default:      prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= 24'd98304;
      ang_gain_q <= 24'd98304;
      lin_lim_q  <= 24'd13107;
      ang_lim_q  <= 24'd13107;
      tol_q      <= 24'd983;
      inv_rad_q  <= 24'd1985939;
      half_trk_q <= 24'd218453;
    end else if (wr_en) begin
      case (idx)
        REG_LIN_GAIN: lin_gain_q <= pwdata[23:0];
        REG_ANG_GAIN: ang_gain_q <= pwdata[23:0];
        REG_LIN_LIM:  lin_lim_q  <= pwdata[23:0];
        REG_ANG_LIM:  ang_lim_q  <= pwdata[23:0];
        REG_TOL:      tol_q      <= pwdata[23:0];
        REG_INV_RAD:  inv_rad_q  <= pwdata[23:0];
        REG_HALF_TRK: half_trk_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  ggpc_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ggpc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .goal_x_i         (s_axis_tdata_i[31:0]),
    .goal_y_i         (s_axis_tdata_i[63:32]),
    .lin_gain_i       (lin_gain_q),
    .ang_gain_i       (ang_gain_q),
    .lin_lim_i        (lin_lim_q),
    .ang_lim_i        (ang_lim_q),
    .tol_i            (tol_q),
    .inv_rad_i        (inv_rad_q),
    .half_trk_i       (half_trk_q),
    .left_setpoint_o  (m_axis_tdata_o[31:0]),
    .right_setpoint_o (m_axis_tdata_o[63:32]),
    .lin_cmd_o        (m_axis_tdata_o[95:64]),
    .ang_cmd_o        (m_axis_tdata_o[127:96]),
    .pose_x_o         (m_axis_tdata_o[159:128]),
    .pose_y_o         (m_axis_tdata_o[191:160]),
    .pose_heading_o   (m_axis_tdata_o[207:192]),
    .arrived_o        (m_axis_tuser_o)
  );

endmodule

>>> dv/ggpc_tb_pkg.sv
`timescale 1ns / 1ps
package ggpc_tb_pkg;

  typedef enum int unsigned {
    REG_LIN_GAIN, REG_ANG_GAIN, REG_LIN_LIMIT, REG_ANG_LIMIT, REG_ARRIVE_TOL,
    REG_INV_RADIUS, REG_HALF_TRACK, REG_COUNT
  } ctrl_reg_e;

  localparam logic [23:0] REG_RESET [REG_COUNT] = '{
    24'd98304, 24'd98304, 24'd13107, 24'd13107, 24'd983, 24'd1985939, 24'd218453
  };

endpackage

>>> dv/ggpc_checker.sv
`timescale 1ns / 1ps
module ggpc_checker import ggpc_tb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         goal_valid_i,
  input  logic         goal_ready_i,
  input  logic [63:0]  goal_data_i,
  input  logic         cmd_valid_i,
  input  logic         cmd_ready_i,
  input  logic [207:0] cmd_data_i,
  input  logic         cmd_user_i,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam longint INV_GAIN = 652032874;
  localparam longint PI_Q29 = 1686629713;
  localparam longint RPM_Q32 = 4101392;
  localparam longint DT_Q32 = 42949673;
  localparam longint DT_BANG = 6835653;
  localparam bit [31:0] ATAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        heading;
    logic               arrived;
  } wheel_cmd_t;

  longint     gain_reg [REG_COUNT];
  longint     pose_x, pose_y;
  bit [15:0]  pose_h;
  wheel_cmd_t cmd_q [$];

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic sin_cos(input longint a, output longint c, output longint s);
    bit     flip;
    longint x, y, z, xn;
    flip = 0;
    x = INV_GAIN;
    y = 0;
    if (a > 16384) begin
      a = a - 32768;
      flip = 1;
    end else if (a < -16384) begin
      a = a + 32768;
      flip = 1;
    end
    z = a * 65536;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i); y = y + (x >>> i); z = z - longint'(ATAN[i]);
      end else begin
        xn = x + (y >>> i); y = y - (x >>> i); z = z + longint'(ATAN[i]);
      end
      x = xn;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic bit [15:0] bearing(longint x, longint y);
    bit [31:0] z;
    longint    xn;
    if (x == 0 && y == 0) return 16'd0;
    z = 0;
    x = x * 16777216;
    y = y * 16777216;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i); y = y - (x >>> i); z = z + ATAN[i];
      end else begin
        xn = x - (y >>> i); y = y + (x >>> i); z = z - ATAN[i];
      end
      x = xn;
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  task automatic predict_tick(input logic [63:0] goal, output wheel_cmd_t r);
    longint dx, dy, dist_m, err, ce, se, ch, sh, proj, lin, ang, erad, wl, wr, stp;
    longint unsigned sq;
    bit [15:0] diff;
    dx = sat32(longint'($signed(goal[31:0])) - pose_x);
    dy = sat32(longint'($signed(goal[63:32])) - pose_y);
    sq = longint'(dx * dx) + longint'(dy * dy);
    dist_m = longint'(int_sqrt(sq));
    r.left = 0;
    r.right = 0;
    if (longint'(int_sqrt(sq)) < gain_reg[REG_ARRIVE_TOL]) begin
      lin = 0;
      ang = 0;
      r.arrived = 1'b1;
    end else begin
      diff = bearing(dx, dy) - pose_h;
      err = longint'($signed(diff));
      sin_cos(err, ce, se);
      proj = round_shift(dist_m * ce, 30);
      lin = clamp_mag(round_shift(gain_reg[REG_LIN_GAIN] * proj, FRAC),
                      gain_reg[REG_LIN_LIMIT]);
      erad = round_shift(err * PI_Q29, 44 - FRAC);
      ang = clamp_mag(round_shift(gain_reg[REG_ANG_GAIN] * erad, FRAC),
                      gain_reg[REG_ANG_LIMIT]);
      wl = round_shift(gain_reg[REG_INV_RADIUS] * lin - gain_reg[REG_HALF_TRACK] * ang, FRAC);
      wr = round_shift(gain_reg[REG_INV_RADIUS] * lin + gain_reg[REG_HALF_TRACK] * ang, FRAC);
      r.left = 32'(sat32(round_shift(wl * RPM_Q32, 32)));
      r.right = 32'(sat32(round_shift(wr * RPM_Q32, 32)));
      sin_cos(longint'($signed(pose_h)), ch, sh);
      stp = round_shift(round_shift(lin * ch, 30) * DT_Q32, 32);
      pose_x = sat32(pose_x + stp);
      stp = round_shift(round_shift(lin * sh, 30) * DT_Q32, 32);
      pose_y = sat32(pose_y + stp);
      stp = round_shift(ang * DT_BANG, FRAC + 16);
      pose_h = pose_h + stp[15:0];
      r.arrived = 1'b0;
    end
    r.lin = lin[31:0];
    r.ang = ang[31:0];
    r.px = pose_x[31:0];
    r.py = pose_y[31:0];
    r.heading = pose_h;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_cmd_t w;
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) gain_reg[i] = REG_RESET[i];
      pose_x = 0;
      pose_y = 0;
      pose_h = 0;
      cmd_q.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00 && paddr[4:2] < REG_COUNT)
        gain_reg[paddr[4:2]] = longint'(pwdata[23:0]);
      if (cmd_valid_i && cmd_ready_i) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: result with no expectation waiting", $realtime);
          fail_count_o++;
        end else begin
          w = cmd_q.pop_front();
          if (cmd_data_i[31:0] !== w.left)
            report("left_setpoint", $signed(cmd_data_i[31:0]), w.left);
          if (cmd_data_i[63:32] !== w.right)
            report("right_setpoint", $signed(cmd_data_i[63:32]), w.right);
          if (cmd_data_i[95:64] !== w.lin)
            report("lin_cmd", $signed(cmd_data_i[95:64]), w.lin);
          if (cmd_data_i[127:96] !== w.ang)
            report("ang_cmd", $signed(cmd_data_i[127:96]), w.ang);
          if (cmd_data_i[159:128] !== w.px)
            report("pose_x", $signed(cmd_data_i[159:128]), w.px);
          if (cmd_data_i[191:160] !== w.py)
            report("pose_y", $signed(cmd_data_i[191:160]), w.py);
          if (cmd_data_i[207:192] !== w.heading)
            report("pose_heading", cmd_data_i[207:192], w.heading);
          if (cmd_user_i !== w.arrived)
            report("arrived", cmd_user_i, w.arrived);
        end
      end
      if (goal_valid_i && goal_ready_i) begin
        predict_tick(goal_data_i, w);
        cmd_q.push_back(w);
      end
      pending_o = cmd_q.size();
    end
  end

  initial fail_count_o = 0;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb import ggpc_tb_pkg::*;;

  logic         clk_i, rst_ni;
  logic         s_valid, s_ready, m_valid, m_ready, m_user;
  logic [63:0]  s_data;
  logic [207:0] m_data;
  logic         psel, penable, pwrite, pready;
  logic [4:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending;
  int           burst_left, n_results, hold_left, rx_tick, rx_mode;
  bit           held;
  logic signed [31:0] last_x, last_y;

  go_to_goal_pose_controller_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .m_axis_tuser_o(m_user),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ggpc_checker chk (
    .clk_i, .rst_ni,
    .goal_valid_i(s_valid), .goal_ready_i(s_ready), .goal_data_i(s_data),
    .cmd_valid_i(m_valid), .cmd_ready_i(m_ready), .cmd_data_i(m_data), .cmd_user_i(m_user),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  always @(posedge clk_i) begin
    if (m_valid && m_ready) begin
      n_results <= n_results + 1;
      last_x <= m_data[159:128];
      last_y <= m_data[191:160];
    end
  end

  always @(negedge clk_i) begin
    rx_tick = rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready = 1'b0;
    end else if (!held && n_results >= 300) begin
      held = 1;
      hold_left = 700;
      m_ready = 1'b0;
    end else begin
      case (rx_mode)
        0: m_ready = 1'b1;
        1: m_ready = 1'($urandom_range(0, 1));
        2: m_ready = ($urandom_range(0, 3) == 0);
        default: m_ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic reg_write(input int unsigned addr, input logic [31:0] val);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = 5'(addr); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_reg(input ctrl_reg_e idx, input logic [23:0] val);
    reg_write(4 * idx, {8'($urandom_range(0, 255)), val});
  endtask

  task automatic set_all(input logic [23:0] val);
    for (int i = 0; i < REG_COUNT; i++) set_reg(ctrl_reg_e'(i), val);
  endtask

  task automatic send_goal(input logic [31:0] gx, input logic [31:0] gy);
    if (burst_left == 0) begin
      s_valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    s_valid = 1'b1;
    s_data = {gy, gx};
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
    burst_left = burst_left - 1;
  endtask

  task automatic drain();
    s_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] near(input logic signed [31:0] c, input int span);
    return c + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_config();
    set_reg(REG_LIN_GAIN,
            24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 24'h60000)));
    set_reg(REG_ANG_GAIN,
            24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 24'h60000)));
    set_reg(REG_LIN_LIMIT,
            24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 24'h20000)));
    set_reg(REG_ANG_LIMIT,
            24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 24'h80000)));
    set_reg(REG_ARRIVE_TOL,
            24'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 24'h4000)));
    set_reg(REG_INV_RADIUS, 24'($urandom));
    set_reg(REG_HALF_TRACK, 24'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    burst_left = 0; n_results = 0; hold_left = 0; held = 0; rx_tick = 0; rx_mode = 0;
    last_x = 0; last_y = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_goal(32'h0, 32'h0);
    send_goal(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_goal(32'h80000000, 32'h80000000);
    send_goal(32'h80000000, 32'h7FFFFFFF);
    send_goal(32'h7FFFFFFF, 32'h80000000);
    send_goal(32'hFFFF0000, 32'h0);
    send_goal(32'h00010000, 32'h0);
    send_goal(32'h0, 32'h00010000);
    send_goal(32'h0, 32'hFFFF0000);
    send_goal(32'hFFFFFFFF, 32'hFFFFFFFF);
    drain();
    send_goal(last_x + 983, last_y);
    drain();
    send_goal(last_x + 982, last_y);
    drain();
    set_reg(REG_ARRIVE_TOL, 24'd0);
    send_goal(last_x, last_y);
    drain();
    set_reg(REG_LIN_LIMIT, 24'd0);
    set_reg(REG_ANG_LIMIT, 24'd0);
    send_goal(32'h00050000, 32'hFFFB0000);
    drain();
    reg_write(28, 32'hFFFFFFFF);
    set_all(24'hFFFFFF);
    set_reg(REG_ARRIVE_TOL, 24'd0);
    send_goal(32'h7FFFFFFF, 32'h00000001);
    send_goal(32'h80000000, 32'hFFFFFFFF);
    send_goal(32'h12345678, 32'h9ABCDEF0);
    drain();
    set_all(24'h000000);
    send_goal(32'h00020000, 32'h00030000);
    send_goal(32'h0, 32'h0);
    drain();
    set_all(24'hFFFFFF);
    send_goal(32'hC0000000, 32'h40000000);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      for (int n = 0; n < 228; n++) begin
        case ($urandom_range(0, 9))
          0, 1: send_goal($urandom, $urandom);
          2: send_goal(near(last_x, 1200), near(last_y, 1200));
          default: send_goal(near(last_x, 1 << $urandom_range(10, 20)),
                             near(last_y, 1 << $urandom_range(10, 20)));
        endcase
      end
      drain();
    end

    repeat (150) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
